### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: entry layout,
// operation codes and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int PRIO_W        = 8;
   localparam int TAG_W         = 8;
   localparam int OCC_W         = 5;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // command seen by every cell in the cycle of a transfer
   typedef struct packed {
      logic      push_en;
      logic      pop_en;
      entry_type entry;
   } cmd_type;

endpackage

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Compares its entry with a pushed entry and
// takes its own, the pushed or a neighbor's entry on each transfer.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic [CNT_W-1:0]   count,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   input  logic               left_keep,
   output logic               keep,
   output spq_pkg::entry_type entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               occupied;
   logic               greater;

   assign occupied = count > CNT_W'(INDEX);
   assign greater  = occupied && (entry_ff.prio > cmd.entry.prio);
   // equal priorities stay ahead of the new entry
   assign keep     = occupied && !greater;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push_en) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = cmd.entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hw/rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of job tags kept sorted in a row of cells; lower
// priority values leave first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                 tuser
//  req      in         priority_req, job_tag               func
//  rsp      out        out_tag, out_priority, occupancy    out_valid, push_refused
//
//  One push or pop is taken per cycle while req_tready is high; its result
//  is registered and shows in the next cycle. Every cell compares against
//  the pushed entry and shifts in parallel across the whole row.
//  Reset clears the entry count and the result valid flag; slot contents are
//  left as they are. A stalled result holds req_tready low only while it
//  cannot be replaced in the same cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // priority_req[7:0], job_tag[15:8]
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_tag[7:0], out_priority[15:8], occupancy[20:16]
   output logic [1:0]  rsp_tuser    // out_valid[0], push_refused[1]
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   logic               accept;
   logic               full;
   logic               empty;
   spq_pkg::func_type  func;
   spq_pkg::cmd_type   cmd;
   spq_pkg::entry_type entry_w [DEPTH];
   logic               keep_w  [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = count_ff == CNT_W'(DEPTH);
   assign empty      = count_ff == '0;
   assign func       = spq_pkg::func_type'(req_tuser[0]);

   assign cmd.push_en    = accept && (func == spq_pkg::FUNC_PUSH) && !full;
   assign cmd.pop_en     = accept && (func == spq_pkg::FUNC_POP) && !empty;
   assign cmd.entry.prio = req_tdata[7:0];
   assign cmd.entry.tag  = req_tdata[15:8];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_e;
      spq_pkg::entry_type right_e;
      logic               left_k;
      if (i == 0) begin : g_head
         assign left_e = cmd.entry;
         assign left_k = 1'b1;
      end else begin : g_body
         assign left_e = entry_w[i-1];
         assign left_k = keep_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_e = entry_w[i];
      end else begin : g_inner
         assign right_e = entry_w[i+1];
      end
      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_keep   (left_k),
         .keep        (keep_w[i]),
         .entry       (entry_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in           = '0;
         rsp_data_in[20:16]    = spq_pkg::OCC_W'(count_in);
         rsp_user_in           = '0;
         if (cmd.pop_en) begin
            rsp_data_in[7:0]   = entry_w[0].tag;
            rsp_data_in[15:8]  = entry_w[0].prio;
            rsp_user_in[0]     = 1'b1;
         end
         if ((func == spq_pkg::FUNC_PUSH) && full) begin
            rsp_user_in[1]     = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      accept && (func == spq_pkg::FUNC_PUSH) && full
      |=> rsp_tuser[1] && (count_ff == CNT_W'(DEPTH)))
      else $error("push into full queue not refused");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_en |=> rsp_tuser[0] && (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not return an entry and drop the count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (entry_w[0].prio <= entry_w[1].prio))
      else $error("head entry out of order");
`endif

endmodule

### dv/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Streams push and pop transfers into the queue and checks every response
// against a sorted-list predictor kept in the bench. Both channels idle at
// random outside a quiet window. A directed part covers empty pops, extreme
// priorities and ties; random fill, drain, mixed and overflow segments
// follow, and the overflow segments reach full-queue refusals.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;

   localparam int DEPTH          = spq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 1350;
   localparam int QUIET_LO       = 600;
   localparam int QUIET_HI       = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PCT       = 9;

   typedef struct {
      spq_pkg::func_type          func;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::TAG_W-1:0]  tag;
      bit                         wait_drain;
   } queue_op_type;

   typedef struct {
      logic                       out_valid;
      logic [spq_pkg::TAG_W-1:0]  out_tag;
      logic [spq_pkg::PRIO_W-1:0] out_prio;
      logic                       push_refused;
      logic [spq_pkg::OCC_W-1:0]  occupancy;
   } queue_rsp_type;

   typedef enum int {
      SEG_FILL,
      SEG_DRAIN,
      SEG_MIXED,
      SEG_OVERFLOW
   } segment_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // priority_req[7:0], job_tag[15:8]
   logic [0:0]  req_tuser  = '0;   // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // out_tag[7:0], out_priority[15:8], occupancy[20:16]
   logic [1:0]  rsp_tuser;         // out_valid[0], push_refused[1]

   queue_op_type  pending_ops[$];
   queue_rsp_type expected_rsp_q[$];

   logic [spq_pkg::PRIO_W-1:0] model_prio[DEPTH];
   logic [spq_pkg::TAG_W-1:0]  model_tag[DEPTH];
   int                         model_count = 0;

   logic req_taken = 1'b0;
   int   cycle_cnt = 0;
   int   stall_cycles = 0;
   int   error_cnt = 0;

   stable_priority_queue #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // sorted insertion: new entry goes ahead of the first strictly greater priority
   function automatic queue_rsp_type sorted_queue_step(spq_pkg::func_type f,
                                                       logic [spq_pkg::PRIO_W-1:0] p,
                                                       logic [spq_pkg::TAG_W-1:0] t);
      queue_rsp_type r;
      int pos;
      r = '{default: '0};
      if (f == spq_pkg::FUNC_PUSH) begin
         if (model_count >= DEPTH) begin
            r.push_refused = 1'b1;
         end else begin
            pos = 0;
            while (pos < model_count && model_prio[pos] <= p) pos++;
            for (int k = model_count; k > pos; k--) begin
               model_prio[k] = model_prio[k-1];
               model_tag[k]  = model_tag[k-1];
            end
            model_prio[pos] = p;
            model_tag[pos]  = t;
            model_count++;
         end
      end else if (model_count > 0) begin
         r.out_valid = 1'b1;
         r.out_prio  = model_prio[0];
         r.out_tag   = model_tag[0];
         for (int k = 1; k < model_count; k++) begin
            model_prio[k-1] = model_prio[k];
            model_tag[k-1]  = model_tag[k];
         end
         model_count--;
      end
      r.occupancy = model_count[spq_pkg::OCC_W-1:0];
      return r;
   endfunction

   task automatic add_op(spq_pkg::func_type f, logic [spq_pkg::PRIO_W-1:0] p,
                         logic [spq_pkg::TAG_W-1:0] t, bit drain = 1'b0);
      queue_op_type op;
      op.func       = f;
      op.prio       = p;
      op.tag        = t;
      op.wait_drain = drain;
      pending_ops.push_back(op);
   endtask

   function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio(bit narrow);
      int r;
      r = $urandom_range(0, 9);
      if (narrow || r < 4) return spq_pkg::PRIO_W'($urandom_range(0, 3));
      if (r == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return spq_pkg::PRIO_W'($urandom_range(0, 255));
   endfunction

   task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, exp_v, got_v);
         error_cnt++;
      end
   endtask

   // feed the request channel and drive rsp_tready at the falling edge
   always @(negedge clock) begin : drive_req
      queue_op_type op;
      bit           quiet;
      quiet = (cycle_cnt >= QUIET_LO) && (cycle_cnt < QUIET_HI);
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_ops.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT) &&
                !(pending_ops[0].wait_drain && expected_rsp_q.size() != 0)) begin
               op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {op.tag, op.prio};
               req_tuser  <= op.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // predict on request transfers, check response transfers
   always @(posedge clock) begin : check_rsp
      queue_rsp_type exp_r;
      if (!reset) begin
         cycle_cnt <= cycle_cnt + 1;
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(sorted_queue_step(spq_pkg::func_type'(req_tuser[0]),
                                                       req_tdata[7:0], req_tdata[15:8]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, %s 0x%0h tuser 0x%0h",
                        $time, "actual tdata", rsp_tdata, rsp_tuser);
               error_cnt++;
            end else begin
               exp_r = expected_rsp_q.pop_front();
               report_field("out_valid",    32'(exp_r.out_valid),    32'(rsp_tuser[0]));
               report_field("push_refused", 32'(exp_r.push_refused), 32'(rsp_tuser[1]));
               report_field("out_tag",      32'(exp_r.out_tag),      32'(rsp_tdata[7:0]));
               report_field("out_priority", 32'(exp_r.out_prio),     32'(rsp_tdata[15:8]));
               report_field("occupancy",    32'(exp_r.occupancy),    32'(rsp_tdata[20:16]));
               report_field("tdata pad",    32'd0,                   32'(rsp_tdata[23:21]));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t ns: watchdog expired with %0d responses outstanding",
                        $time, expected_rsp_q.size());
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      segment_kind_type kind;
      int               seg_len;
      int               seg_idx;
      bit               narrow;
      bit               do_push;

      // directed: empty pop, extremes, ties keep arrival order, drain to empty
      add_op(spq_pkg::FUNC_POP,  8'h00, 8'h00);
      add_op(spq_pkg::FUNC_PUSH, 8'hFF, 8'h00);
      add_op(spq_pkg::FUNC_PUSH, 8'h00, 8'hFF);
      add_op(spq_pkg::FUNC_PUSH, 8'h08, 8'h01);
      add_op(spq_pkg::FUNC_PUSH, 8'h08, 8'h02);
      add_op(spq_pkg::FUNC_PUSH, 8'h08, 8'h03);
      add_op(spq_pkg::FUNC_PUSH, 8'h00, 8'h5A);
      add_op(spq_pkg::FUNC_PUSH, 8'hFF, 8'hA5);
      repeat (9) add_op(spq_pkg::FUNC_POP, 8'hFF, 8'hFF);

      seg_idx = 0;
      while (pending_ops.size() < RANDOM_ITEMS) begin
         kind    = segment_kind_type'($urandom_range(0, 3));
         seg_len = $urandom_range(10, 60);
         narrow  = ($urandom_range(0, 1) != 0);
         if (kind == SEG_OVERFLOW) begin
            // run past full, then past empty
            for (int i = 0; i < DEPTH + 3; i++)
               add_op(spq_pkg::FUNC_PUSH, pick_prio(narrow), spq_pkg::TAG_W'($urandom),
                      (i == 0) && (seg_idx % 6 == 0));
            for (int i = 0; i < DEPTH + 3; i++)
               add_op(spq_pkg::FUNC_POP, spq_pkg::PRIO_W'($urandom),
                      spq_pkg::TAG_W'($urandom));
         end else begin
            for (int i = 0; i < seg_len; i++) begin
               case (kind)
                  SEG_FILL:  do_push = ($urandom_range(0, 99) < 85);
                  SEG_DRAIN: do_push = ($urandom_range(0, 99) < 15);
                  default:   do_push = ($urandom_range(0, 99) < 50);
               endcase
               add_op(do_push ? spq_pkg::FUNC_PUSH : spq_pkg::FUNC_POP, pick_prio(narrow),
                      spq_pkg::TAG_W'($urandom), (i == 0) && (seg_idx % 6 == 0));
            end
         end
         seg_idx++;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_ops.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### stable_priority_queue.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
dv/stable_priority_queue_tb.sv
